>>> src/intel_hex_record_loader_macros.svh
// Assertion macros shared by the Intel HEX record loader modules.
`ifndef INTEL_HEX_RECORD_LOADER_MACROS_SVH
`define INTEL_HEX_RECORD_LOADER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define HEXRL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HEXRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/hexrl_pkg.sv
// Shared types and constants of the Intel HEX record loader.
`default_nettype none

package hexrl_pkg;

    localparam int ADDRESS_BITS_DEFAULT = 16;

    localparam int CFG_BITS = 17;
    localparam logic [CFG_BITS-1:0] BUFFER_SIZE_RESET = 17'h10000;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [7:0] MARKER_LOW  = 8'hD7;
    localparam logic [7:0] MARKER_HIGH = 8'hFB;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd2;
    localparam logic [1:0] STATUS_MARKER   = 2'd3;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [7:0]  data;
        logic [1:0]  status;
    } t_result;

endpackage

`default_nettype wire

>>> src/hexrl_parser.sv
// Record parser: parse state and the per-character next-state and result logic.
`default_nettype none
`include "intel_hex_record_loader_macros.svh"

module hexrl_parser #(
    parameter int ADDRESS_BITS = hexrl_pkg::ADDRESS_BITS_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic [7:0]                     i_char,
    input  wire logic                           i_eoi,
    input  wire logic [hexrl_pkg::CFG_BITS-1:0] i_buffer_size,
    output logic                                o_res_valid,
    output hexrl_pkg::t_result                  o_res
);

    localparam logic [15:0] AddrMask = 16'((17'd1 << ADDRESS_BITS) - 17'd1);

    typedef enum logic [3:0] {
        PH_WAIT,
        PH_SKIP,
        PH_LEN,
        PH_ADDR_HI,
        PH_ADDR_LO,
        PH_TYPE,
        PH_DATA,
        PH_CHECK,
        PH_TAIL,
        PH_DONE
    } t_phase;

    t_phase      r_phase,       n_phase;
    logic [3:0]  r_high_nibble, n_high_nibble;
    logic        r_digit_half,  n_digit_half;
    logic [7:0]  r_sum,         n_sum;
    logic [7:0]  r_left,        n_left;
    logic [15:0] r_addr,        n_addr;
    logic [7:0]  r_type,        n_type;
    logic [1:0]  r_err,         n_err;
    logic        r_finished,    n_finished;
    logic [7:0]  r_mark_lo,     n_mark_lo;
    logic [7:0]  r_mark_hi,     n_mark_hi;

    logic [3:0]  digit;
    logic [7:0]  byte_val;
    logic [7:0]  sum_next;
    logic [16:0] rec_end;

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = 4'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

    // Where to go once a payload byte has been taken.
    function automatic t_phase after_payload(input logic [7:0] left, input logic [1:0] err);
        t_phase p;
        if (left != 8'd0) begin
            p = PH_DATA;
        end else if (err != hexrl_pkg::STATUS_OK) begin
            p = PH_DONE;
        end else begin
            p = PH_CHECK;
        end
        return p;
    endfunction

    assign digit    = digit_value(i_char);
    assign byte_val = {r_high_nibble, digit};
    assign sum_next = r_sum + byte_val;
    assign rec_end  = {1'b0, r_addr} + {9'd0, r_left};

    always_comb begin
        n_phase       = r_phase;
        n_high_nibble = r_high_nibble;
        n_digit_half  = r_digit_half;
        n_sum         = r_sum;
        n_left        = r_left;
        n_addr        = r_addr;
        n_type        = r_type;
        n_err         = r_err;
        n_finished    = r_finished;
        n_mark_lo     = r_mark_lo;
        n_mark_hi     = r_mark_hi;
        o_res_valid   = 1'b0;
        o_res         = '0;

        if (i_eoi) begin
            o_res_valid = 1'b1;
            o_res.kind  = hexrl_pkg::KIND_STATUS;
            o_res.status = r_err;
            if (r_err == hexrl_pkg::STATUS_OK &&
                (r_mark_lo != hexrl_pkg::MARKER_LOW || r_mark_hi != hexrl_pkg::MARKER_HIGH)) begin
                o_res.status = hexrl_pkg::STATUS_MARKER;
            end
            n_phase       = PH_WAIT;
            n_high_nibble = 4'd0;
            n_digit_half  = 1'b0;
            n_sum         = 8'd0;
            n_left        = 8'd0;
            n_addr        = 16'd0;
            n_type        = 8'd0;
            n_err         = hexrl_pkg::STATUS_OK;
            n_finished    = 1'b0;
            n_mark_lo     = 8'd0;
            n_mark_hi     = 8'd0;
        end else begin
            unique case (r_phase)
                PH_WAIT: begin
                    if (i_char == hexrl_pkg::CHAR_COLON) begin
                        n_sum        = 8'd0;
                        n_digit_half = 1'b0;
                        n_phase      = PH_LEN;
                    end else if (i_char != hexrl_pkg::CHAR_SPACE &&
                                 i_char != hexrl_pkg::CHAR_LF) begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP, PH_TAIL: begin
                    if (i_char == hexrl_pkg::CHAR_LF) begin
                        n_phase = PH_WAIT;
                    end
                end
                PH_DONE: begin
                end
                PH_LEN, PH_ADDR_HI, PH_ADDR_LO, PH_TYPE, PH_DATA, PH_CHECK: begin
                    if (i_char == hexrl_pkg::CHAR_LF) begin
                        // A line end inside a record drops it without a checksum test.
                        n_digit_half = 1'b0;
                        n_phase = (r_err != hexrl_pkg::STATUS_OK) ? PH_DONE : PH_WAIT;
                    end else if (!r_digit_half) begin
                        n_high_nibble = digit;
                        n_digit_half  = 1'b1;
                    end else begin
                        n_digit_half = 1'b0;
                        n_sum        = sum_next;
                        unique case (r_phase)
                            PH_LEN: begin
                                n_left  = byte_val;
                                n_phase = PH_ADDR_HI;
                            end
                            PH_ADDR_HI: begin
                                n_addr  = {byte_val, 8'd0};
                                n_phase = PH_ADDR_LO;
                            end
                            PH_ADDR_LO: begin
                                n_addr  = {r_addr[15:8], byte_val};
                                n_phase = PH_TYPE;
                            end
                            PH_TYPE: begin
                                n_type = byte_val;
                                if (byte_val == hexrl_pkg::REC_DATA && rec_end > i_buffer_size) begin
                                    n_err = hexrl_pkg::STATUS_OVERFLOW;
                                end
                                n_phase = after_payload(r_left, n_err);
                            end
                            PH_DATA: begin
                                if (r_type == hexrl_pkg::REC_DATA &&
                                    {1'b0, r_addr} < i_buffer_size) begin
                                    if (r_addr == 16'd0) n_mark_lo = byte_val;
                                    if (r_addr == 16'd1) n_mark_hi = byte_val;
                                    o_res_valid   = 1'b1;
                                    o_res.kind    = hexrl_pkg::KIND_WRITE;
                                    o_res.address = r_addr & AddrMask;
                                    o_res.data    = byte_val;
                                end
                                n_addr  = r_addr + 16'd1;
                                n_left  = r_left - 8'd1;
                                n_phase = after_payload(n_left, r_err);
                            end
                            default: begin
                                // Checksum byte.
                                if (sum_next != 8'd0) begin
                                    n_err   = hexrl_pkg::STATUS_CHECKSUM;
                                    n_phase = PH_DONE;
                                end else if (r_type == hexrl_pkg::REC_EOF) begin
                                    n_finished = 1'b1;
                                    n_phase    = PH_DONE;
                                end else begin
                                    n_phase = PH_TAIL;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    n_phase = PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_WAIT;
            r_high_nibble <= 4'd0;
            r_digit_half  <= 1'b0;
            r_sum         <= 8'd0;
            r_left        <= 8'd0;
            r_addr        <= 16'd0;
            r_type        <= 8'd0;
            r_err         <= hexrl_pkg::STATUS_OK;
            r_finished    <= 1'b0;
            r_mark_lo     <= 8'd0;
            r_mark_hi     <= 8'd0;
        end else if (i_en) begin
            r_phase       <= n_phase;
            r_high_nibble <= n_high_nibble;
            r_digit_half  <= n_digit_half;
            r_sum         <= n_sum;
            r_left        <= n_left;
            r_addr        <= n_addr;
            r_type        <= n_type;
            r_err         <= n_err;
            r_finished    <= n_finished;
            r_mark_lo     <= n_mark_lo;
            r_mark_hi     <= n_mark_hi;
        end
    end

    `HEXRL_ASSERT_IMP(a_finished_stops, i_clk, i_rst_n, r_finished, r_phase == PH_DONE,
        "finished load is not stopped")
    `HEXRL_ASSERT_IMP(a_error_phase, i_clk, i_rst_n, r_err != hexrl_pkg::STATUS_OK,
        r_phase == PH_DATA || r_phase == PH_DONE, "pending error outside data or done")
    `HEXRL_ASSERT_IMP(a_half_in_record, i_clk, i_rst_n, r_digit_half,
        r_phase == PH_LEN || r_phase == PH_ADDR_HI || r_phase == PH_ADDR_LO ||
        r_phase == PH_TYPE || r_phase == PH_DATA || r_phase == PH_CHECK,
        "half digit held outside a record")

endmodule

`default_nettype wire

>>> src/hexrl_out_reg.sv
// Result register between the parser and the output channel.
`default_nettype none

module hexrl_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire logic               i_res_valid,
    input  wire hexrl_pkg::t_result i_res,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output logic                    o_free,
    output hexrl_pkg::t_result      o_res
);

    logic               r_valid, n_valid;
    hexrl_pkg::t_result r_res;

    // The slot can take a new result when empty or when its request leaves now.
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = i_res_valid;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

>>> src/intel_hex_record_loader.sv
// Intel HEX record loader: one character in per cycle while the output does not stall, one request out at most.
// A request taken at a clock edge is held in the input register and parsed once the result slot
// can take its outcome; its result is registered in that slot and leaves at an edge where the output does not stall.
// Throughput is one character per cycle while the output does not stall, set by the single parse step per character.
// Synchronous active-low reset clears the parse state and sets buffer_size to 65536.
`default_nettype none
`include "intel_hex_record_loader_macros.svh"

module intel_hex_record_loader #(
    parameter int ADDRESS_BITS = hexrl_pkg::ADDRESS_BITS_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [hexrl_pkg::CFG_BITS-1:0] i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [7:0]                     i_character,
    input  wire logic                           i_end_of_input,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_result_kind,
    output logic [15:0]                         o_write_address,
    output logic [7:0]                          o_write_data,
    output logic [1:0]                          o_load_status
);

    logic [hexrl_pkg::CFG_BITS-1:0] r_buffer_size;

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eoi;

    logic               advance;
    logic               out_free;
    logic               res_valid;
    hexrl_pkg::t_result res;
    hexrl_pkg::t_result out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= hexrl_pkg::BUFFER_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_buffer_size <= i_cfg_data;
        end
    end

    // The held character is parsed when the result slot can take its outcome.
    assign advance = r_in_valid && out_free;
    assign o_stall = r_in_valid && !advance;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_valid && !o_stall) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_char <= i_character;
            r_in_eoi  <= i_end_of_input;
        end
    end

    hexrl_parser #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_char        (r_in_char),
        .i_eoi         (r_in_eoi),
        .i_buffer_size (r_buffer_size),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    hexrl_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_free      (out_free),
        .o_res       (out_res)
    );

    assign o_result_kind   = out_res.kind;
    assign o_write_address = out_res.address;
    assign o_write_data    = out_res.data;
    assign o_load_status   = out_res.status;

    `HEXRL_ASSERT_IMP(a_stall_needs_item, i_clk, i_rst_n, o_stall, r_in_valid,
        "input stalled with no held request")
    `HEXRL_ASSERT_NEXT(a_held_item_kept, i_clk, i_rst_n, o_stall,
        r_in_valid && $stable(r_in_char) && $stable(r_in_eoi), "held request changed")
    `HEXRL_ASSERT_IMP(a_write_status_zero, i_clk, i_rst_n,
        o_valid && o_result_kind == hexrl_pkg::KIND_WRITE,
        o_load_status == hexrl_pkg::STATUS_OK, "write request carries a status")

endmodule

`default_nettype wire

>>> sim/intel_hex_record_loader_test.sv
// Self-checking testbench for the Intel HEX record loader with random character streams.
module intel_hex_record_loader_test;
    import hexrl_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // How a record's text is cut short.
    localparam int NO_CUT = 0;
    localparam int CUT_LINE = 1;
    localparam int OPEN_END = 2;

    typedef enum logic [3:0] {
        WAIT_LINE, SKIP_LINE, GET_LENGTH, GET_ADDR_HI, GET_ADDR_LO,
        GET_TYPE, GET_DATA, GET_CHECKSUM, SKIP_TAIL, LOAD_STOPPED
    } parse_phase_e;

    class hex_load_scoreboard;
        logic [CFG_BITS-1:0] buffer_size;
        parse_phase_e phase;
        logic [3:0] high_digit;
        logic second_digit;
        logic [7:0] check_sum;
        logic [7:0] bytes_left;
        logic [15:0] load_address;
        logic [7:0] record_kind;
        logic [1:0] error_status;
        logic [7:0] byte_at_0;
        logic [7:0] byte_at_1;
        t_result expected_results[$];
        int mismatches;

        function new();
            buffer_size = BUFFER_SIZE_RESET;
            mismatches = 0;
            start_over();
        endfunction

        function void start_over();
            phase = WAIT_LINE;
            high_digit = '0;
            second_digit = 1'b0;
            check_sum = '0;
            bytes_left = '0;
            load_address = '0;
            record_kind = '0;
            error_status = STATUS_OK;
            byte_at_0 = '0;
            byte_at_1 = '0;
        endfunction

        // The low nibble of an ASCII digit gives its value directly; a letter's low nibble plus nine gives its value.
        function logic [3:0] digit_of(logic [7:0] c);
            if (c >= "0" && c <= "9") return c[3:0];
            if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return 4'(c[3:0] + 4'd9);
            return 4'd0;
        endfunction

        function void next_after_byte();
            if (bytes_left != 0) phase = GET_DATA;
            else if (error_status != STATUS_OK) phase = LOAD_STOPPED;
            else phase = GET_CHECKSUM;
        endfunction

        // Advances the parser by one accepted request and queues any result it causes.
        function void take_request(logic [7:0] c, logic eoi);
            t_result r;
            logic [7:0] b;
            if (eoi) begin
                r.kind = KIND_STATUS;
                r.address = '0;
                r.data = '0;
                r.status = error_status;
                if (error_status == STATUS_OK &&
                    (byte_at_0 != MARKER_LOW || byte_at_1 != MARKER_HIGH))
                    r.status = STATUS_MARKER;
                expected_results.push_back(r);
                start_over();
                return;
            end
            case (phase)
                WAIT_LINE: begin
                    if (c == CHAR_COLON) begin
                        check_sum = '0;
                        second_digit = 1'b0;
                        phase = GET_LENGTH;
                    end else if (c != CHAR_SPACE && c != CHAR_LF) begin
                        phase = SKIP_LINE;
                    end
                end
                SKIP_LINE, SKIP_TAIL: begin
                    if (c == CHAR_LF) phase = WAIT_LINE;
                end
                LOAD_STOPPED: ;
                default: begin
                    if (c == CHAR_LF) begin
                        second_digit = 1'b0;
                        phase = (error_status != STATUS_OK) ? LOAD_STOPPED : WAIT_LINE;
                    end else if (!second_digit) begin
                        high_digit = digit_of(c);
                        second_digit = 1'b1;
                    end else begin
                        second_digit = 1'b0;
                        b = {high_digit, digit_of(c)};
                        check_sum = check_sum + b;
                        case (phase)
                            GET_LENGTH: begin
                                bytes_left = b;
                                phase = GET_ADDR_HI;
                            end
                            GET_ADDR_HI: begin
                                load_address = {b, 8'h00};
                                phase = GET_ADDR_LO;
                            end
                            GET_ADDR_LO: begin
                                load_address[7:0] = b;
                                phase = GET_TYPE;
                            end
                            GET_TYPE: begin
                                record_kind = b;
                                if (record_kind == REC_DATA &&
                                    ({1'b0, load_address} + {9'd0, bytes_left}) > buffer_size)
                                    error_status = STATUS_OVERFLOW;
                                next_after_byte();
                            end
                            GET_DATA: begin
                                if (record_kind == REC_DATA &&
                                    {1'b0, load_address} < buffer_size) begin
                                    if (load_address == 16'd0) byte_at_0 = b;
                                    if (load_address == 16'd1) byte_at_1 = b;
                                    r.kind = KIND_WRITE;
                                    r.address = load_address;
                                    r.data = b;
                                    r.status = STATUS_OK;
                                    expected_results.push_back(r);
                                end
                                load_address = load_address + 16'd1;
                                bytes_left = bytes_left - 8'd1;
                                next_after_byte();
                            end
                            default: begin
                                if (check_sum != 0) begin
                                    error_status = STATUS_CHECKSUM;
                                    phase = LOAD_STOPPED;
                                end else if (record_kind == REC_EOF) begin
                                    phase = LOAD_STOPPED;
                                end else begin
                                    phase = SKIP_TAIL;
                                end
                            end
                        endcase
                    end
                end
            endcase
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d address %h data %h status %0d",
                       got.kind, got.address, got.data, got.status);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got.kind !== want.kind) begin
                $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.address !== want.address) begin
                $error("write_address: expected %h, got %h", want.address, got.address);
                mismatches++;
            end
            if (got.data !== want.data) begin
                $error("write_data: expected %h, got %h", want.data, got.data);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("load_status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_BITS-1:0] i_cfg_data;
    logic i_valid;
    logic o_stall;
    logic [7:0] i_character;
    logic i_end_of_input;
    logic o_valid;
    logic i_stall;
    logic o_result_kind;
    logic [15:0] o_write_address;
    logic [7:0] o_write_data;
    logic [1:0] o_load_status;

    hex_load_scoreboard sb = new();
    logic [7:0] record_data[$];
    int sent_chars = 0;
    int send_calm = 0;
    int cycles = 0;

    intel_hex_record_loader dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_character(i_character),
        .i_end_of_input(i_end_of_input),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_result_kind(o_result_kind),
        .o_write_address(o_write_address),
        .o_write_data(o_write_data),
        .o_load_status(o_load_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_result_kind, o_write_address, o_write_data, o_load_status});
    end

    // Result side: mostly short stalls, a few long ones, and stretches without any.
    initial begin
        int hold;
        int calm;
        int r;
        i_stall = 1'b0;
        hold = 0;
        calm = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else if (calm > 0) begin
                calm--;
                i_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) calm = $urandom_range(50, 300);
                else if (r < 70) calm = $urandom_range(0, 4);
                else if (r < 95) hold = $urandom_range(1, 3);
                else hold = $urandom_range(8, 40);
                i_stall <= 1'b0;
            end
        end
    end

    function int next_gap();
        int r;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            send_calm = $urandom_range(40, 200);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function logic is_hex(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function logic [7:0] junk_char();
        logic [7:0] c;
        do c = 8'($urandom); while (c == CHAR_LF);
        return c;
    endfunction

    function logic [7:0] non_hex_char();
        logic [7:0] c;
        do c = junk_char(); while (is_hex(c));
        return c;
    endfunction

    function logic [7:0] hex_char(logic [3:0] n);
        if (n < 10) return 8'("0" + n);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
    endfunction

    function void fill_data(int n);
        record_data.delete();
        repeat (n) record_data.push_back(8'($urandom));
    endfunction

    function int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(0, 8);
        if (r < 98) return $urandom_range(9, 32);
        return $urandom_range(33, 255);
    endfunction

    function logic [15:0] pick_address(int len);
        int r;
        int top;
        r = $urandom_range(0, 99);
        top = int'(sb.buffer_size) - len;
        if (top > 65535) top = 65535;
        if (r < 70) return (top > 0) ? 16'($urandom_range(0, top)) : 16'h0000;
        if (r < 85) return 16'($urandom);
        if (r < 93) return 16'(65535 - $urandom_range(0, 8));
        return 16'($urandom_range(0, 3));
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eoi);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_character <= c;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (o_stall);
        sb.take_request(c, eoi);
        sent_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
    endtask

    // With noise on, every zero digit goes out as a character that is not a hex digit.
    task automatic send_digit(input logic [3:0] n, input logic noisy);
        if (noisy && n == 4'd0) send_char(non_hex_char(), 1'b0);
        else send_char(hex_char(n), 1'b0);
    endtask

    task automatic send_record(input logic [7:0] rtype, input logic [15:0] addr,
                               input logic bad_sum, input int cut, input logic noisy);
        logic [7:0] bytes[$];
        logic [7:0] sum;
        int stop;
        bytes = {8'(record_data.size()), addr[15:8], addr[7:0], rtype};
        foreach (record_data[i]) bytes.push_back(record_data[i]);
        sum = '0;
        foreach (bytes[i]) sum = sum + bytes[i];
        sum = 8'(0 - sum);
        if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
        bytes.push_back(sum);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_char(CHAR_SPACE, 1'b0);
        send_char(CHAR_COLON, 1'b0);
        stop = (cut == NO_CUT) ? bytes.size() : $urandom_range(0, bytes.size() - 1);
        for (int i = 0; i < stop; i++) begin
            send_digit(bytes[i][7:4], noisy);
            send_digit(bytes[i][3:0], noisy);
        end
        if (cut != NO_CUT && $urandom_range(0, 1)) send_char(hex_char(4'($urandom)), 1'b0);
        if (cut == OPEN_END) return;
        if (cut == NO_CUT) begin
            if ($urandom_range(0, 4) == 0) send_char(CHAR_CR, 1'b0);
            if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 4)) send_char(junk_char(), 1'b0);
        end
        send_char(CHAR_LF, 1'b0);
    endtask

    task automatic send_comment_line();
        logic [7:0] c;
        do c = junk_char(); while (c == CHAR_COLON || c == CHAR_SPACE);
        send_char(c, 1'b0);
        repeat ($urandom_range(0, 10)) send_char(junk_char(), 1'b0);
        send_char(CHAR_LF, 1'b0);
    endtask

    task automatic send_noise_burst();
        repeat ($urandom_range(1, 12)) send_char(8'($urandom), 1'b0);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_buffer_size(input logic [CFG_BITS-1:0] size);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= size;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.buffer_size = size;
    endtask

    // One file: a few records, mostly well formed, usually closed by an end record.
    task automatic random_file();
        int n_records;
        int marker_at;
        int r;
        int len;
        logic noisy;
        n_records = $urandom_range(1, 6);
        marker_at = ($urandom_range(0, 9) < 7) ? $urandom_range(0, n_records - 1) : -1;
        noisy = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n_records; i++) begin
            r = $urandom_range(0, 99);
            if (i == marker_at) begin
                record_data = {MARKER_LOW, MARKER_HIGH};
                repeat ($urandom_range(0, 3)) record_data.push_back(8'($urandom));
                send_record(REC_DATA, 16'h0000, $urandom_range(0, 24) == 0, NO_CUT, noisy);
            end else if (r < 6) begin
                send_comment_line();
            end else if (r < 10) begin
                send_noise_burst();
            end else begin
                len = pick_length();
                fill_data(len);
                send_record((r < 18) ? 8'($urandom_range(2, 255)) : REC_DATA,
                            pick_address(len), $urandom_range(0, 24) == 0,
                            ($urandom_range(0, 24) == 0) ? CUT_LINE : NO_CUT, noisy);
            end
        end
        if ($urandom_range(0, 9) < 6) begin
            fill_data(($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
            send_record(REC_EOF, 16'($urandom), $urandom_range(0, 24) == 0, NO_CUT, noisy);
            if ($urandom_range(0, 3) == 0) send_comment_line();
        end
        if ($urandom_range(0, 9) == 0) begin
            len = pick_length();
            fill_data(len);
            send_record(REC_DATA, pick_address(len), 1'b0, OPEN_END, noisy);
        end
        send_char(8'($urandom), 1'b1);
        if ($urandom_range(0, 11) == 0) wait_idle();
    endtask

    initial begin
        logic [CFG_BITS-1:0] sizes[8];
        int budgets[8];
        int goal;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_character = '0;
        i_end_of_input = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A clean load with the marker, under the buffer size from reset.
        send_text("  \n");
        send_text(";note\n");
        record_data = {MARKER_LOW, MARKER_HIGH};
        send_record(REC_DATA, 16'h0000, 1'b0, NO_CUT, 1'b0);
        record_data = {8'h00, 8'hF0, 8'h0F};
        send_record(REC_DATA, 16'h0010, 1'b0, NO_CUT, 1'b1);
        record_data = {8'hFF};
        send_record(REC_DATA, 16'hFFFF, 1'b0, NO_CUT, 1'b0);
        record_data = {8'h12, 8'h34};
        send_record(8'h04, 16'h0000, 1'b0, NO_CUT, 1'b0);
        record_data = {8'h55, 8'hAA, 8'h01};
        send_record(REC_DATA, 16'h0100, 1'b0, CUT_LINE, 1'b0);
        fill_data(0);
        send_record(REC_EOF, 16'h0000, 1'b0, NO_CUT, 1'b0);
        send_text(":0100000011EE\n");
        send_char(CHAR_COLON, 1'b1);

        // Overflow whose writes wrap around to the marker addresses.
        record_data = {8'h01, 8'h02, MARKER_LOW, MARKER_HIGH};
        send_record(REC_DATA, 16'hFFFE, 1'b0, NO_CUT, 1'b0);
        send_char(8'hFF, 1'b1);

        set_buffer_size('0);
        record_data = {8'h11};
        send_record(REC_DATA, 16'h0000, 1'b0, NO_CUT, 1'b0);
        send_char(8'h00, 1'b1);

        set_buffer_size(BUFFER_SIZE_RESET);
        record_data = {MARKER_LOW, MARKER_HIGH};
        send_record(REC_DATA, 16'h0000, 1'b1, NO_CUT, 1'b0);
        send_char(CHAR_LF, 1'b1);
        send_char(CHAR_LF, 1'b1);
        record_data = {8'h01, 8'h02};
        send_record(REC_DATA, 16'h0000, 1'b0, OPEN_END, 1'b0);
        send_char(CHAR_SPACE, 1'b1);

        sizes = '{BUFFER_SIZE_RESET, 17'd0, 17'd1, 17'd300, 17'hFFFF, 17'd2,
                  17'($urandom_range(3, 65534)), BUFFER_SIZE_RESET};
        budgets = '{300, 120, 120, 300, 300, 120, 300, 300};
        goal = 0;
        sent_chars = 0;
        for (int p = 0; p < 8; p++) begin
            set_buffer_size(sizes[p]);
            goal += budgets[p];
            while (sent_chars < goal) random_file();
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> intel_hex_record_loader.f
+incdir+src
src/hexrl_pkg.sv
src/hexrl_parser.sv
src/hexrl_out_reg.sv
src/intel_hex_record_loader.sv
sim/intel_hex_record_loader_test.sv
